// ===== rtl/core/cau_pkg.sv =====
// shared operation and status codes for the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2,
		ST_RSV = 2'd3
	} status_t;

endpackage

// ===== rtl/core/cau_req_if.sv =====
// request channel: operation code and two complex operands
`timescale 1ns / 1ps
interface cau_req_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	cau_pkg::op_t                 operation;
	logic signed [DATA_WIDTH-1:0] a_real;
	logic signed [DATA_WIDTH-1:0] a_imag;
	logic signed [DATA_WIDTH-1:0] b_real;
	logic signed [DATA_WIDTH-1:0] b_imag;

	modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ===== rtl/core/cau_rsp_if.sv =====
// response channel: complex result and status
`timescale 1ns / 1ps
interface cau_rsp_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_real;
	logic signed [DATA_WIDTH-1:0] result_imag;
	cau_pkg::status_t             status;

	modport source (output valid, result_real, result_imag, status, input ready);
	modport sink (input valid, result_real, result_imag, status, output ready);
endinterface

// ===== rtl/core/cau_pipe_ctrl.sv =====
// valid bits and per-stage load enables of the pipeline
`timescale 1ns / 1ps
module cau_pipe_ctrl #(
	parameter int NST = 21
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_ready,
	output logic           in_ready,
	output logic           out_valid,
	output logic [NST-1:0] en
);
	logic [NST-1:0] v_q;

	always_comb begin
		en[NST-1] = !v_q[NST-1] | out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !v_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NST-1];
endmodule

// ===== rtl/core/cau_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module cau_div_lane #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                      clk,
	input  logic [DATA_WIDTH:0]       en,
	input  logic [3*DATA_WIDTH+FRAC_BITS+1:0] rem_in,
	input  logic [2*DATA_WIDTH-1:0]   den_in,
	output logic [DATA_WIDTH:0]       quo
);
	localparam int QW  = DATA_WIDTH + 1;
	localparam int DNW = 2 * DATA_WIDTH;
	localparam int RW  = 3 * DATA_WIDTH + FRAC_BITS + 2;

	logic [RW-1:0]  rem_s [QW];
	logic [DNW-1:0] den_s [QW];
	logic [QW-1:0]  quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0]  rem_p;
		logic [RW-1:0]  shd;
		logic [DNW-1:0] den_p;
		logic [QW-1:0]  quo_p;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign den_p = den_in;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		assign shd = RW'(den_p) << (QW - 1 - k);
		assign ge  = rem_p >= shd;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= ge ? rem_p - shd : rem_p;
				den_s[k] <= den_p;
				quo_s[k] <= {quo_p[QW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QW-1];
endmodule

// ===== rtl/core/complex_arith_unit.sv =====
// complex add, subtract, multiply and divide on signed fixed-point operands
// throughput: one transfer per cycle unless the response stalls; divide runs one quotient bit per stage
// a stall at the response holds every stage, empty stages still fill
// reset clears the valid bits only; the datapath registers are not reset
`timescale 1ns / 1ps
module complex_arith_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input logic       clk,
	input logic       arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);
	import cau_pkg::*;

	localparam int DW  = DATA_WIDTH;
	localparam int PW  = 2 * DW;
	localparam int SW  = 2 * DW + 1;
	localparam int DNW = 2 * DW;
	localparam int QW  = DW + 1;
	localparam int RW  = 3 * DW + FRAC_BITS + 2;
	localparam int NST = QW + 4;

	localparam logic signed [SW-1:0] WMAX_X = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SW-1:0] WMIN_X = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] WMAX_W = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] WMIN_W = {1'b1, {(DW-1){1'b0}}};
	localparam logic [QW-1:0] NLIM   = QW'(1) << (DW - 1);

	function automatic logic [DW:0] sat_fn(input logic signed [SW-1:0] v);
		logic [DW:0] r;
		if (v > WMAX_X) begin
			r = {1'b1, WMAX_W};
		end else if (v < WMIN_X) begin
			r = {1'b1, WMIN_W};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

	function automatic logic [DW:0] quo_fn(input logic neg, input logic big,
		input logic [QW-1:0] q);
		logic [DW:0]   r;
		logic [QW-1:0] nq;
		nq = ~q + QW'(1);
		if (big) begin
			r = {1'b1, neg ? WMIN_W : WMAX_W};
		end else if (!neg) begin
			if (q[QW-1:DW-1] != '0) begin
				r = {1'b1, WMAX_W};
			end else begin
				r = {1'b0, q[DW-1:0]};
			end
		end else begin
			if (q > NLIM) begin
				r = {1'b1, WMIN_W};
			end else begin
				r = {1'b0, nq[DW-1:0]};
			end
		end
		return r;
	endfunction

	logic [NST-1:0] en;

	cau_pipe_ctrl #(.NST(NST)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.en        (en)
	);

	// products and add/sub
	op_t               op_s1;
	logic signed [PW-1:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	logic signed [DW:0]   asre_s1, asim_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1 <= req.operation;
			ac_s1 <= req.a_real * req.b_real;
			bd_s1 <= req.a_imag * req.b_imag;
			ad_s1 <= req.a_real * req.b_imag;
			bc_s1 <= req.a_imag * req.b_real;
			cc_s1 <= req.b_real * req.b_real;
			dd_s1 <= req.b_imag * req.b_imag;
			if (req.operation == OP_SUB) begin
				asre_s1 <= (DW+1)'(req.a_real) - (DW+1)'(req.b_real);
				asim_s1 <= (DW+1)'(req.a_imag) - (DW+1)'(req.b_imag);
			end else begin
				asre_s1 <= (DW+1)'(req.a_real) + (DW+1)'(req.b_real);
				asim_s1 <= (DW+1)'(req.a_imag) + (DW+1)'(req.b_imag);
			end
		end
	end

	// product sums and divisor
	op_t                  op_s2;
	logic signed [SW-1:0] mre_s2, mim_s2, nre_s2, nim_s2;
	logic [DNW-1:0]       den_s2;
	logic signed [DW:0]   asre_s2, asim_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s2   <= op_s1;
			mre_s2  <= SW'(ac_s1) - SW'(bd_s1);
			mim_s2  <= SW'(ad_s1) + SW'(bc_s1);
			nre_s2  <= SW'(ac_s1) + SW'(bd_s1);
			nim_s2  <= SW'(bc_s1) - SW'(ad_s1);
			den_s2  <= DNW'($unsigned(cc_s1)) + DNW'($unsigned(dd_s1));
			asre_s2 <= asre_s1;
			asim_s2 <= asim_s1;
		end
	end

	// direct results and divider set-up
	logic [DW:0]   dre_c, dim_c;
	logic [SW-1:0] magre_c, magim_c;
	logic [RW-1:0] remre_c, remim_c, dsh_c;

	always_comb begin
		unique case (op_s2)
			OP_ADD, OP_SUB: begin
				dre_c = sat_fn(SW'(asre_s2));
				dim_c = sat_fn(SW'(asim_s2));
			end
			OP_MUL: begin
				dre_c = sat_fn(mre_s2 >>> FRAC_BITS);
				dim_c = sat_fn(mim_s2 >>> FRAC_BITS);
			end
			OP_DIV: begin
				dre_c = '0;
				dim_c = '0;
			end
		endcase
		magre_c = nre_s2[SW-1] ? $unsigned(-nre_s2) : $unsigned(nre_s2);
		magim_c = nim_s2[SW-1] ? $unsigned(-nim_s2) : $unsigned(nim_s2);
		remre_c = RW'(magre_c) << FRAC_BITS;
		remim_c = RW'(magim_c) << FRAC_BITS;
		dsh_c   = RW'(den_s2) << QW;
	end

	logic          div_s [QW+1];
	logic          dz_s [QW+1];
	logic          sat_s [QW+1];
	logic [DW-1:0] rr_s [QW+1];
	logic [DW-1:0] ri_s [QW+1];
	logic          negre_s [QW+1];
	logic          negim_s [QW+1];
	logic          bigre_s [QW+1];
	logic          bigim_s [QW+1];
	logic [RW-1:0] remre_s3, remim_s3;
	logic [DNW-1:0] den_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			div_s[0]   <= op_s2 == OP_DIV;
			dz_s[0]    <= den_s2 == '0;
			sat_s[0]   <= dre_c[DW] | dim_c[DW];
			rr_s[0]    <= dre_c[DW-1:0];
			ri_s[0]    <= dim_c[DW-1:0];
			negre_s[0] <= nre_s2[SW-1];
			negim_s[0] <= nim_s2[SW-1];
			bigre_s[0] <= remre_c >= dsh_c;
			bigim_s[0] <= remim_c >= dsh_c;
			remre_s3   <= remre_c;
			remim_s3   <= remim_c;
			den_s3     <= den_s2;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[2+k]) begin
				div_s[k]   <= div_s[k-1];
				dz_s[k]    <= dz_s[k-1];
				sat_s[k]   <= sat_s[k-1];
				rr_s[k]    <= rr_s[k-1];
				ri_s[k]    <= ri_s[k-1];
				negre_s[k] <= negre_s[k-1];
				negim_s[k] <= negim_s[k-1];
				bigre_s[k] <= bigre_s[k-1];
				bigim_s[k] <= bigim_s[k-1];
			end
		end
	end

	logic [QW-1:0] qre, qim;

	cau_div_lane #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk    (clk),
		.en     (en[3 +: QW]),
		.rem_in (remre_s3),
		.den_in (den_s3),
		.quo    (qre)
	);

	cau_div_lane #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_im (
		.clk    (clk),
		.en     (en[3 +: QW]),
		.rem_in (remim_s3),
		.den_in (den_s3),
		.quo    (qim)
	);

	// final select, sign and saturation
	logic [DW:0]   fre_c, fim_c;
	logic [DW-1:0] ore_c, oim_c;
	status_t       ost_c;

	always_comb begin
		fre_c = quo_fn(negre_s[QW], bigre_s[QW], qre);
		fim_c = quo_fn(negim_s[QW], bigim_s[QW], qim);
		priority if (!div_s[QW]) begin
			ore_c = rr_s[QW];
			oim_c = ri_s[QW];
			ost_c = sat_s[QW] ? ST_SAT : ST_OK;
		end else if (dz_s[QW]) begin
			ore_c = '0;
			oim_c = '0;
			ost_c = ST_DZ;
		end else begin
			ore_c = fre_c[DW-1:0];
			oim_c = fim_c[DW-1:0];
			ost_c = (fre_c[DW] | fim_c[DW]) ? ST_SAT : ST_OK;
		end
	end

	logic [DW-1:0] res_re_q, res_im_q;
	status_t       res_st_q;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			res_re_q <= ore_c;
			res_im_q <= oim_c;
			res_st_q <= ost_c;
		end
	end

	assign rsp.result_real = res_re_q;
	assign rsp.result_imag = res_im_q;
	assign rsp.status      = res_st_q;
endmodule
